@@ sv/mbrpb_pkg.sv @@
// Shared types, constants and the playfield packing function of the bitmap row blitter.
package mbrpb_pkg;

   // Default geometry
   localparam int ARENA_LINES_DEF = 256;
   localparam int SCREEN_PIXELS   = 40;
   localparam int STORE_GROUPS    = 12;   // two buffers of six playfield columns
   localparam int PF_BYTES        = 6;

   // Item kinds carried in req_tuser
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Register indexes (paddr[3:2])
   localparam logic [1:0] REG_SCROLL_X   = 2'd0;
   localparam logic [1:0] REG_SCROLL_Y   = 2'd1;
   localparam logic [1:0] REG_BUFFER_SEL = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_RMW,
      ST_FLUSH,
      ST_DONE
   } state_type;

   // Access request from the sequencer to the frame store
   typedef struct packed {
      logic rd_en;
      logic merge;
   } store_ctl_type;

   // Map one 40-pixel line onto six playfield bytes, unmapped bits zero
   function automatic logic [47:0] pf_pack(input logic [39:0] line);
      logic [47:0] r;
      int          q;
      int          b;
      int          t;
      r = '0;
      for (int c = 0; c < SCREEN_PIXELS; c++) begin
         if (c >= 20) begin
            q = c - 20;
         end else begin
            q = c;
         end
         if (q < 4) begin
            b = 0;
            t = 4 + q;
         end else if (q < 12) begin
            b = 1;
            t = 11 - q;
         end else begin
            b = 2;
            t = q - 12;
         end
         if (c >= 20) begin
            b = b + 3;
         end
         r[b*8+t] = line[c];
      end
      return r;
   endfunction

endpackage

@@ sv/masked_bitmap_row_playfield_blit.sv @@
// Top level of the masked bitmap row blitter: register port, draw sequencer and read path.
//
//   channel  | ports                  | carries
//   ---------+------------------------+------------------------------------------
//   request  | req_tvalid/tready/...  | one draw row or one frame-store read a beat
//   response | rsp_tvalid/tready/...  | one result beat per request beat
//   csr      | csr_psel/penable/...   | scroll_x, scroll_y, buffer_select
//
// A read issues its store access from ST_C1, the state after accept, and loads its result
// beat in ST_DONE once the response register is free. A draw runs the prep states ST_C1 to
// ST_C4 and, when it passes clipping, a read-modify-write of each of the six playfield
// columns on each of three sub-scanlines on the single store port, then ST_FLUSH; a clipped
// draw goes from ST_C4 to ST_DONE. The next request is taken in ST_IDLE after the load, so
// one item is in work at a time. After reset a clearing pass zeroes the store; no request
// is accepted until it ends. A stalled response holds the sequencer in its last state; a
// new request can be accepted while a result waits.
module masked_bitmap_row_playfield_blit
   import mbrpb_pkg::*;
#(
   parameter int ARENA_LINES = ARENA_LINES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request: tuser = op
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,
   // request tdata, low bit up: x_pos[31:0], y_pos[63:32], anchor_x[71:64],
   // anchor_y[79:72], width_bytes[82:80], height_rows[90:83], row_index[98:91],
   // row_bits[130:99], row_mask[162:131], colour[165:163], read_address[177:166]
   input  logic [183:0] req_tdata,
   // response tdata, low bit up: read_data[7:0], drawn[8]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int DEPTH = STORE_GROUPS * ARENA_LINES;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(ARENA_LINES);
   localparam logic [31:0] ARENA_FIX = 32'(ARENA_LINES) << 16;
   localparam logic [31:0] SCREEN_FIX = 32'(SCREEN_PIXELS) << 14;

   // Configuration registers
   logic [31:0] scroll_x_ff;
   logic [31:0] scroll_y_ff;
   logic        buffer_sel_ff;

   // Sequencer
   state_type   state_ff, state_in;

   // Latched item
   logic        op_ff;
   logic [31:0] x_ff, y_ff;
   logic [7:0]  ax_ff, ay_ff, h_ff, row_ff;
   logic [2:0]  w_ff, colour_ff;
   logic [31:0] bits_ff, mask_ff;
   logic [11:0] raddr_ff;

   // Prep pipeline
   logic [31:0] dx_ff, sy3_ff, t_ff, yoff_ff, ty_ff;
   logic [31:0] pv_ff, mv_ff;
   logic [18:0] absb_ff;
   logic [17:0] scan_full_ff;
   logic        pass_x_ff;
   logic [39:0] dl_ff, ml_ff;
   logic [47:0] pk_data_ff, pk_keep_ff;
   logic [LW-1:0] scan_ff;
   logic        rd_ok_ff;
   logic        drawn_ff;

   // Read-modify-write walk
   logic [1:0]  sub_ff;
   logic [2:0]  col_ff;

   // Response register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;

   // Store interface
   store_ctl_type st_ctl;
   logic [AW-1:0] st_addr;
   logic [7:0]    st_keep, st_data, st_q;
   logic          st_busy;

   logic          csr_wr;
   logic          req_acc;
   logic          out_free;
   logic [2:0]    w_in;
   logic [31:0]   aligned_b, aligned_m;
   logic [31:0]   pix_l, pix_r, pix_b;
   logic [71:0]   shd, shm;
   logic [18:0]   neg_absb;
   logic          pass_y, row_ok, scan_ok;
   logic          rd_ok;
   logic [LW:0]   line;
   logic          line_ok;
   logic [3:0]    grp;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff   <= '0;
         scroll_y_ff   <= '0;
         buffer_sel_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_SCROLL_X:   scroll_x_ff   <= csr_pwdata;
            REG_SCROLL_Y:   scroll_y_ff   <= csr_pwdata;
            REG_BUFFER_SEL: buffer_sel_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_paddr[3:2])
         REG_SCROLL_X:   csr_prdata = scroll_x_ff;
         REG_SCROLL_Y:   csr_prdata = scroll_y_ff;
         REG_BUFFER_SEL: csr_prdata = {31'b0, buffer_sel_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Clamp the row width
   assign w_in = (req_tdata[82:80] > 3'd4) ? 3'd4 : req_tdata[82:80];

   // Align row data so the first pixel sits in bit 31
   always_comb begin
      case (w_ff)
         3'd0: begin
            aligned_b = '0;
            aligned_m = '0;
         end
         3'd1: begin
            aligned_b = bits_ff << 24;
            aligned_m = mask_ff << 24;
         end
         3'd2: begin
            aligned_b = bits_ff << 16;
            aligned_m = mask_ff << 16;
         end
         3'd3: begin
            aligned_b = bits_ff << 8;
            aligned_m = mask_ff << 8;
         end
         default: begin
            aligned_b = bits_ff;
            aligned_m = mask_ff;
         end
      endcase
   end

   // Horizontal clip values
   assign pix_l = t_ff & 32'hFFFF_C000;
   assign pix_r = pix_l + (32'(w_ff) << 14);

   // Place the row on the 40-pixel line
   assign neg_absb = -absb_ff;
   always_comb begin
      shd = '0;
      shm = '0;
      if (!absb_ff[18] && absb_ff < 19'd40) begin
         shd = 72'(pv_ff) << absb_ff[5:0];
         shm = 72'(mv_ff) << absb_ff[5:0];
      end else if (absb_ff[18] && $signed(absb_ff) >= -19'sd31) begin
         shd = 72'(pv_ff >> neg_absb[4:0]);
         shm = 72'(mv_ff >> neg_absb[4:0]);
      end
   end

   // Vertical clip and scanline tests
   assign pix_b   = ty_ff + ({16'b0, 16'(10'(h_ff) * 10'd3)} << 16);
   assign pass_y  = ~pix_b[31] & ($signed(ty_ff) < $signed(ARENA_FIX));
   assign row_ok  = row_ff < h_ff;
   assign scan_ok = ~scan_full_ff[17] & ($signed(scan_full_ff) < $signed(18'(ARENA_LINES)));

   assign rd_ok = {20'b0, raddr_ff} < 32'(DEPTH);

   // Store address of the current read-modify-write
   assign line    = {1'b0, scan_ff} + (LW + 1)'(sub_ff);
   assign line_ok = line < (LW + 1)'(ARENA_LINES);
   assign grp     = (buffer_sel_ff ? 4'd6 : 4'd0) + {1'b0, col_ff};

   // Next state and store requests
   always_comb begin
      state_in     = state_ff;
      st_ctl.rd_en = 1'b0;
      st_ctl.merge = 1'b0;
      st_addr      = AW'(raddr_ff);
      st_keep      = pk_keep_ff[col_ff*8 +: 8];
      st_data      = colour_ff[2'd2 - sub_ff] ? pk_data_ff[col_ff*8 +: 8] : 8'h00;
      case (state_ff)
         ST_CLEAR: begin
            if (!st_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_C1;
            end
         end
         ST_C1: begin
            if (op_ff == OP_READ) begin
               st_ctl.rd_en = rd_ok;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_C2;
            end
         end
         ST_C2: state_in = ST_C3;
         ST_C3: state_in = ST_C4;
         ST_C4: begin
            if (pass_x_ff && pass_y && row_ok && scan_ok) begin
               state_in = ST_RMW;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RMW: begin
            st_ctl.rd_en = line_ok;
            st_ctl.merge = 1'b1;
            st_addr      = AW'(AW'(grp) * AW'(ARENA_LINES)) + AW'(line);
            if (sub_ff == 2'd2 && col_ff == 3'(PF_BYTES - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Latch the item and run the prep datapath
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff     <= req_tuser;
         x_ff      <= req_tdata[31:0];
         y_ff      <= req_tdata[63:32];
         ax_ff     <= req_tdata[71:64];
         ay_ff     <= req_tdata[79:72];
         w_ff      <= w_in;
         h_ff      <= req_tdata[90:83];
         row_ff    <= req_tdata[98:91];
         bits_ff   <= req_tdata[130:99];
         mask_ff   <= req_tdata[162:131];
         colour_ff <= req_tdata[165:163];
         raddr_ff  <= req_tdata[177:166];
      end
      case (state_ff)
         ST_C1: begin
            dx_ff    <= x_ff - scroll_x_ff;
            sy3_ff   <= {scroll_y_ff[31:16], 16'b0} + {scroll_y_ff[30:16], 17'b0};
            rd_ok_ff <= rd_ok;
            drawn_ff <= 1'b0;
            for (int k = 0; k < 32; k++) begin
               pv_ff[k] <= aligned_b[31-k];
               mv_ff[k] <= aligned_m[31-k];
            end
         end
         ST_C2: begin
            t_ff    <= dx_ff - (32'(ax_ff) << 14);
            absb_ff <= {dx_ff[31], dx_ff[31:14]} - {11'b0, ax_ff};
            yoff_ff <= y_ff - sy3_ff;
         end
         ST_C3: begin
            pass_x_ff    <= ~pix_r[31] & ($signed(pix_l) < $signed(SCREEN_FIX));
            ty_ff        <= yoff_ff - (32'(ay_ff) << 16);
            scan_full_ff <= 18'(10'(row_ff) * 10'd3) - {10'b0, ay_ff}
                            + {{2{yoff_ff[31]}}, yoff_ff[31:16]};
            dl_ff        <= shd[39:0];
            ml_ff        <= shm[39:0];
         end
         ST_C4: begin
            pk_data_ff <= pf_pack(dl_ff);
            pk_keep_ff <= ~pf_pack(ml_ff);
            scan_ff    <= scan_full_ff[LW-1:0];
            drawn_ff   <= pass_x_ff & pass_y & row_ok & scan_ok;
         end
         default: ;
      endcase
   end

   // Walk sub-scanlines and playfield columns
   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         col_ff <= '0;
      end else if (state_ff == ST_C4) begin
         sub_ff <= '0;
         col_ff <= '0;
      end else if (state_ff == ST_RMW) begin
         if (col_ff == 3'(PF_BYTES - 1)) begin
            col_ff <= '0;
            sub_ff <= sub_ff + 2'd1;
         end else begin
            col_ff <= col_ff + 3'd1;
         end
      end
   end

   // Load the response beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {7'b0, drawn_ff,
                         (op_ff == OP_READ && rd_ok_ff) ? st_q : 8'h00};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mbrpb_store #(
      .ARENA_LINES (ARENA_LINES),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .addr    (st_addr),
      .keep    (st_keep),
      .data    (st_data),
      .rd_data (st_q),
      .busy    (st_busy)
   );

endmodule

@@ sv/mbrpb_store.sv @@
// Frame store memory with clearing pass after reset and a merge write in the cycle after its read.
module mbrpb_store
   import mbrpb_pkg::*;
#(
   parameter int ARENA_LINES = ARENA_LINES_DEF,
   parameter int AW          = $clog2(STORE_GROUPS * ARENA_LINES)
) (
   input  logic          clock,
   input  logic          reset,
   input  store_ctl_type ctl,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    keep,
   input  logic [7:0]    data,
   output logic [7:0]    rd_data,
   output logic          busy
);

   localparam int DEPTH = STORE_GROUPS * ARENA_LINES;

   logic [7:0]    mem [DEPTH];
   logic [7:0]    q_ff;
   logic          pend_ff;
   logic [AW-1:0] wa_ff;
   logic [7:0]    keep_ff;
   logic [7:0]    wdata_ff;
   logic [AW-1:0] clr_ff;
   logic          busy_ff;

   // Clear sweep, merge write of the byte read last cycle, registered read
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_ff] <= 8'h00;
      end else if (pend_ff) begin
         mem[wa_ff] <= (q_ff & keep_ff) | wdata_ff;
      end
      if (ctl.rd_en) begin
         q_ff <= mem[addr];
      end
   end

   // Register the address, keep mask and data of the pending merge
   always_ff @(posedge clock) begin
      wa_ff    <= addr;
      keep_ff  <= keep;
      wdata_ff <= data;
   end

   // Clear counter and pending flag
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctl.rd_en & ctl.merge & ~busy_ff;
         if (busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rd_data = q_ff;
   assign busy    = busy_ff;

endmodule

@@ test/masked_bitmap_row_playfield_blit_tb.sv @@
// Self-checking testbench of the masked bitmap row blitter: shaped random draws, reads and register phases.
module masked_bitmap_row_playfield_blit_tb;
   import mbrpb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARENA          = ARENA_LINES_DEF;
   localparam int STORE_BYTES    = STORE_GROUPS * ARENA;
   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 30;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 20000;

   // Request beat payload, most significant field first
   typedef struct packed {
      logic [5:0]  pad;
      logic [11:0] read_address;
      logic [2:0]  colour;
      logic [31:0] row_mask;
      logic [31:0] row_bits;
      logic [7:0]  row_index;
      logic [7:0]  height_rows;
      logic [2:0]  width_bytes;
      logic [7:0]  anchor_y;
      logic [7:0]  anchor_x;
      logic [31:0] y_pos;
      logic [31:0] x_pos;
   } blit_item_t;

   typedef struct {
      logic [7:0] read_data;
      logic       drawn;
   } blit_result_t;

   // Shadow frame store and registers; predicts each result in accept order
   class playfield_mirror;
      logic [7:0]   store [STORE_BYTES];
      logic [31:0]  scroll_x;
      logic [31:0]  scroll_y;
      logic         buf_sel;
      blit_result_t pending_results[$];
      int           errors;

      function new();
         foreach (store[i]) store[i] = '0;
         scroll_x = '0;
         scroll_y = '0;
         buf_sel  = 1'b0;
         errors   = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_SCROLL_X:   scroll_x = value;
            REG_SCROLL_Y:   scroll_y = value;
            REG_BUFFER_SEL: buf_sel  = value[0];
            default: ;
         endcase
      endfunction

      // Clip one row, then merge its three sub-scanlines into the store
      function bit blit_row(blit_item_t it);
         logic [31:0]        dx, left, yoff, top, bottom;
         logic signed [31:0] dxs, ys;
         logic [2:0]         w;
         logic [7:0]         keep [6];
         logic [7:0]         dat [3][6];
         int                 first_col, scan, col, src, nbits, q, pf_byte, pf_bit, sub_line;
         int                 addr;
         w = (it.width_bytes > 3'd4) ? 3'd4 : it.width_bytes;
         dx = it.x_pos - scroll_x;
         left = (dx - (32'(it.anchor_x) << 14)) & 32'hFFFFC000;
         if ($signed(left + (32'(w) << 14)) < 0 || $signed(left) >= SCREEN_PIXELS * 16384)
            return 1'b0;
         yoff = it.y_pos - (scroll_y & 32'hFFFF0000) * 32'd3;
         top = yoff - (32'(it.anchor_y) << 16);
         bottom = top + ((32'(it.height_rows) * 32'd3) << 16);
         if ($signed(bottom) < 0 || $signed(top) >= ARENA * 65536)
            return 1'b0;
         if (it.row_index >= it.height_rows)
            return 1'b0;
         ys = yoff;
         ys = ys >>> 16;
         scan = int'(it.row_index) * 3 - int'(it.anchor_y) + ys;
         if (scan < 0 || scan >= ARENA)
            return 1'b0;
         for (int c = 0; c < PF_BYTES; c++) begin
            keep[c] = 8'hFF;
            for (int s = 0; s < 3; s++) dat[s][c] = '0;
         end
         dxs = dx;
         first_col = (dxs >>> 14) - int'(it.anchor_x);
         nbits = int'(w) * 8;
         // Place each pixel: byte 0 high nibble, byte 1 reversed, byte 2 forward
         for (int k = 0; k < nbits; k++) begin
            col = first_col + k;
            src = nbits - 1 - k;
            if (col < 0 || col >= SCREEN_PIXELS) continue;
            q = col % 20;
            if (q < 4) begin
               pf_byte = 0;
               pf_bit  = q + 4;
            end else if (q < 12) begin
               pf_byte = 1;
               pf_bit  = 11 - q;
            end else begin
               pf_byte = 2;
               pf_bit  = q - 12;
            end
            if (col >= 20) pf_byte += 3;
            if (it.row_mask[src]) keep[pf_byte][pf_bit] = 1'b0;
            if (it.row_bits[src]) begin
               for (int s = 0; s < 3; s++)
                  if (it.colour[2-s]) dat[s][pf_byte][pf_bit] = 1'b1;
            end
         end
         // Merge, dropping sub-scanlines past the arena
         for (int s = 0; s < 3; s++) begin
            sub_line = scan + s;
            if (sub_line >= ARENA) continue;
            for (int c = 0; c < PF_BYTES; c++) begin
               addr = int'(buf_sel) * PF_BYTES * ARENA + c * ARENA + sub_line;
               store[addr] = (store[addr] & keep[c]) | dat[s][c];
            end
         end
         return 1'b1;
      endfunction

      function void note_request(logic op, blit_item_t it);
         blit_result_t r;
         r.read_data = '0;
         r.drawn     = 1'b0;
         if (op == OP_READ) begin
            if (int'(it.read_address) < STORE_BYTES) r.read_data = store[it.read_address];
         end else begin
            r.drawn = blit_row(it);
         end
         pending_results.push_back(r);
      endfunction

      function void check_result(logic [7:0] read_data, logic drawn);
         blit_result_t r;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: read_data %02h drawn %0b",
                     $time, read_data, drawn);
            errors++;
            return;
         end
         r = pending_results.pop_front();
         if (read_data !== r.read_data) begin
            $display("%0t: read_data mismatch: expected %02h, actual %02h",
                     $time, r.read_data, read_data);
            errors++;
         end
         if (drawn !== r.drawn) begin
            $display("%0t: drawn mismatch: expected %0b, actual %0b", $time, r.drawn, drawn);
            errors++;
         end
      endfunction

      function int waiting();
         return pending_results.size();
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic         req_tuser   = 1'b0;
   logic [183:0] req_tdata   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [15:0]  rsp_tdata;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [3:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   playfield_mirror mirror = new();
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;
   int hold_requests  = 0;
   int last_line      = 0;
   int idle_cycles    = 0;

   masked_bitmap_row_playfield_blit #(
      .ARENA_LINES(ARENA)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #CLK_HALF clock = ~clock;

   // Predict on accepted requests, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) mirror.note_request(req_tuser, blit_item_t'(req_tdata));
         if (rsp_tvalid && rsp_tready) mirror.check_result(rsp_tdata[7:0], rsp_tdata[8]);
      end
   end

   // Abort when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("masked_bitmap_row_playfield_blit_tb failed");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin : sink_ctrl
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Offer one beat, with random gaps ahead of it; called and returns at a falling edge
   task automatic send_item(input logic op, input blit_item_t it);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= it;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (mirror.waiting() != 0) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Write a register, mirror it, and read it back
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] rd;
      logic [31:0] want;
      csr_access(1'b1, idx, value, rd);
      mirror.set_reg(idx, value);
      csr_access(1'b0, idx, '0, rd);
      want = (idx == REG_BUFFER_SEL) ? {31'b0, value[0]} : value;
      if (rd !== want) begin
         $display("%0t: register %0d readback mismatch: expected %08h, actual %08h",
                  $time, idx, want, rd);
         mirror.errors++;
      end
   endtask

   task automatic configure(input logic [31:0] sx, input logic [31:0] sy, input logic bsel);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      write_reg(REG_SCROLL_X, sx);
      write_reg(REG_SCROLL_Y, sy);
      write_reg(REG_BUFFER_SEL, {31'b0, bsel});
   endtask

   function automatic blit_item_t noise_item();
      blit_item_t it;
      it = {6'b0, 12'($urandom), 3'($urandom), $urandom, $urandom, 8'($urandom), 8'($urandom),
            3'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom};
      return it;
   endfunction

   // Build a draw that lands on a chosen pixel column and scanline under the current scroll
   function automatic blit_item_t make_draw(int col, int sub_line, logic [2:0] w, logic [7:0] h,
                                            logic [7:0] row, logic [7:0] ax, logic [7:0] ay,
                                            logic [31:0] bits, logic [31:0] msk,
                                            logic [2:0] colour);
      blit_item_t it;
      it = noise_item();
      it.x_pos = mirror.scroll_x + 32'((col + int'(ax)) * 16384) + 32'($urandom_range(16383));
      it.y_pos = (mirror.scroll_y & 32'hFFFF0000) * 32'd3
               + 32'((sub_line - 3 * int'(row) + int'(ay)) * 65536) + 32'($urandom_range(65535));
      it.anchor_x    = ax;
      it.anchor_y    = ay;
      it.width_bytes = w;
      it.height_rows = h;
      it.row_index   = row;
      it.row_bits    = bits;
      it.row_mask    = msk;
      it.colour      = colour;
      return it;
   endfunction

   function automatic blit_item_t read_item(logic [11:0] addr);
      blit_item_t it;
      it = noise_item();
      it.read_address = addr;
      return it;
   endfunction

   // Mostly on-screen rows, some near the arena top and bottom, with odd sizes now and then
   function automatic blit_item_t shaped_draw();
      int          col;
      int          sub_line;
      int          pick;
      logic [7:0]  h;
      logic [7:0]  row;
      logic [2:0]  w;
      logic [31:0] msk;
      pick = $urandom_range(9);
      if (pick == 0) sub_line = ARENA - 6 + int'($urandom_range(8));
      else if (pick == 1) sub_line = int'($urandom_range(5)) - 3;
      else sub_line = $urandom_range(ARENA - 1);
      col = int'($urandom_range(73)) - 33;
      w = ($urandom_range(9) < 8) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7));
      h = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(255, 1));
      row = ($urandom_range(9) == 0 || h == 0) ? 8'($urandom_range(255))
                                               : 8'($urandom_range(int'(h) - 1));
      pick = $urandom_range(9);
      msk = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : $urandom;
      last_line = sub_line;
      return make_draw(col, sub_line, w, h, row, 8'($urandom_range(255)),
                       8'($urandom_range(255)), $urandom, msk, 3'($urandom_range(7)));
   endfunction

   task automatic run_random(input int count);
      int         pick;
      logic [11:0] addr;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // Read back mostly around the last drawn line
            if ($urandom_range(9) < 7) begin
               addr = 12'($urandom_range(1) * PF_BYTES * ARENA + $urandom_range(5) * ARENA
                          + ((last_line + int'($urandom_range(2))) & (ARENA - 1)));
            end else begin
               addr = 12'($urandom);
            end
            send_item(OP_READ, read_item(addr));
         end else if (pick < 90) begin
            send_item(OP_DRAW, shaped_draw());
         end else begin
            send_item(OP_DRAW, noise_item());
         end
      end
   endtask

   initial begin : stimulus
      blit_item_t it;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: edges, clips, odd sizes and reads, reset register values
      send_item(OP_READ, read_item(12'd0));
      send_item(OP_DRAW, make_draw(0, 0, 3'd4, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7));
      send_item(OP_READ, read_item(12'd0));
      send_item(OP_READ, read_item(12'(2 * ARENA)));
      send_item(OP_DRAW, make_draw(-31, 10, 3'd4, 8'd3, 8'd1, 8'd5, 8'd2,
                                   32'hA5A5A5A5, 32'hFFFFFFFF, 3'd4));
      send_item(OP_DRAW, make_draw(36, 20, 3'd4, 8'd1, 8'd0, 8'd9, 8'd0,
                                   $urandom, $urandom, 3'd2));
      send_item(OP_DRAW, make_draw(40, 30, 3'd4, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7));
      send_item(OP_DRAW, make_draw(-32, 30, 3'd4, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7));
      send_item(OP_DRAW, make_draw(-33, 30, 3'd4, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7));
      send_item(OP_DRAW, make_draw(0, ARENA - 2, 3'd4, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'h0F0F0F0F, 3'd7));
      send_item(OP_DRAW, make_draw(8, ARENA - 1, 3'd2, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'h0000FFFF, 32'h0000FFFF, 3'd1));
      send_item(OP_DRAW, make_draw(8, ARENA, 3'd2, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'h0000FFFF, 32'h0000FFFF, 3'd7));
      send_item(OP_DRAW, make_draw(8, -1, 3'd2, 8'd2, 8'd0, 8'd0, 8'd0,
                                   32'h0000FFFF, 32'h0000FFFF, 3'd7));
      send_item(OP_DRAW, make_draw(8, 50, 3'd2, 8'd5, 8'd5, 8'd0, 8'd0,
                                   32'h0000FFFF, 32'h0000FFFF, 3'd7));
      send_item(OP_DRAW, make_draw(8, 50, 3'd2, 8'd0, 8'd0, 8'd0, 8'd0,
                                   32'h0000FFFF, 32'h0000FFFF, 3'd7));
      send_item(OP_DRAW, make_draw(4, 40, 3'd0, 8'd1, 8'd0, 8'd0, 8'd0,
                                   32'hFFFFFFFF, 32'hFFFFFFFF, 3'd7));
      send_item(OP_DRAW, make_draw(4, 41, 3'd7, 8'd1, 8'd0, 8'd0, 8'd0,
                                   $urandom, $urandom, 3'd6));
      send_item(OP_DRAW, make_draw(12, 42, 3'd3, 8'd1, 8'd0, 8'd0, 8'd0,
                                   $urandom, 32'h0, 3'd5));
      it = make_draw(0, 0, 3'd4, 8'd255, 8'd255, 8'd255, 8'd255, '1, '1, 3'd7);
      it.x_pos = 32'h7FFFFFFF;
      it.y_pos = 32'h80000000;
      send_item(OP_DRAW, it);
      it = make_draw(0, 0, 3'd4, 8'd255, 8'd254, 8'd0, 8'd0, '1, '1, 3'd3);
      it.x_pos = 32'h80000000;
      it.y_pos = 32'h7FFFFFFF;
      send_item(OP_DRAW, it);
      send_item(OP_READ, read_item(12'(STORE_BYTES - 1)));
      send_item(OP_READ, read_item(12'(STORE_BYTES)));
      send_item(OP_READ, read_item(12'hFFF));
      send_item(OP_READ, read_item(12'(ARENA + ARENA - 1)));
      send_item(OP_READ, read_item(12'(3 * ARENA + 10)));

      // No idling, second buffer
      configure($urandom, $urandom, 1'b1);
      run_random(450);

      // Sender mostly idle
      configure(32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0);
      src_idle_pct = 88;
      run_random(250);

      // Receiver mostly stalled
      configure(32'h80000000, 32'h80000000, 1'b1);
      src_idle_pct   = 0;
      sink_stall_pct = 88;
      run_random(400);

      // Both idling, with a long receiver hold-off and a full drain
      configure(32'hFFFFFFFF, $urandom, 1'b0);
      src_idle_pct   = 27;
      sink_stall_pct = 27;
      run_random(100);
      hold_requests++;
      run_random(60);
      wait_drained();
      run_random(300);

      // No idling again, other extremes
      configure(32'h00000000, 32'hFFFF0000, 1'b1);
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      run_random(400);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mirror.errors == 0 && mirror.waiting() == 0) begin
         $display("masked_bitmap_row_playfield_blit_tb passed");
      end else begin
         $display("masked_bitmap_row_playfield_blit_tb failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mbrpb_pkg.sv
sv/mbrpb_store.sv
sv/masked_bitmap_row_playfield_blit.sv
test/masked_bitmap_row_playfield_blit_tb.sv
